FILE: sv/journal_record_validator_defines.svh
// ----------------------------------------------------------------------------
// Journal record validator assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef JOURNAL_RECORD_VALIDATOR_DEFINES_SVH
`define JOURNAL_RECORD_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define JRV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("journal record validator: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define JRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("journal record validator: next-cycle check failed");

`endif

FILE: sv/jrv_pkg.sv
// ----------------------------------------------------------------------------
// Journal record validator package
// Shared types and constants for the front end, back end and top level.
// ----------------------------------------------------------------------------
package jrv_pkg;

    // FNV-1a 32-bit constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Record header characters.
    localparam logic [7:0] CHAR_N       = 8'h4E;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Final record status codes.
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_CHECK  = 3'd1,
        ST_MAGIC  = 3'd2,
        ST_NUMBER = 3'd3,
        ST_COUNT  = 3'd4,
        ST_TRUNC  = 3'd5,
        ST_TRAIL  = 3'd6
    } status_t;

    // One classified input byte as it waits in the queue.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] check;
        logic        is_digit;
        logic [3:0]  digit;
        logic        is_newline;
        logic [2:0]  magic_hit;
    } entry_t;

endpackage

FILE: sv/jrv_front.sv
// ----------------------------------------------------------------------------
// Journal record validator front end
// Accepts input bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module jrv_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             final_byte,
    input  logic [31:0]      stored_check,
    output logic             q_valid,
    output jrv_pkg::entry_t  q_entry,
    input  logic             q_pop
);

    jrv_pkg::entry_t                 mem [jrv_pkg::QUEUE_DEPTH];
    jrv_pkg::entry_t                 new_entry;
    logic [jrv_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [jrv_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [jrv_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [jrv_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [jrv_pkg::QCNT_W-1:0]      count_reg;
    logic [jrv_pkg::QCNT_W-1:0]      count_next;
    logic                            push;
    logic                            pop;

    // Classify the incoming byte for the parser.
    always_comb
    begin
        new_entry            = '0;
        new_entry.data       = data_byte;
        new_entry.last       = final_byte;
        new_entry.check      = stored_check;
        new_entry.is_digit   = data_byte inside {[8'h30:8'h39]};
        new_entry.digit      = data_byte[3:0];
        new_entry.is_newline = (data_byte == jrv_pkg::CHAR_NEWLINE);
        new_entry.magic_hit  = {data_byte == jrv_pkg::CHAR_NEWLINE,
                                data_byte == jrv_pkg::CHAR_ONE,
                                data_byte == jrv_pkg::CHAR_N};
    end

    // Queue handshake on both sides.
    assign in_ready = (count_reg != jrv_pkg::QCNT_W'(jrv_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

FILE: sv/jrv_back.sv
// ----------------------------------------------------------------------------
// Journal record validator back end
// Hashes and parses queued bytes and drives the registered result.
// ----------------------------------------------------------------------------
module jrv_back
#(
    parameter int MAX_EVENTS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  jrv_pkg::entry_t  q_entry,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             event_byte_valid,
    output logic [7:0]       event_byte,
    output logic [2:0]       event_index,
    output logic             record_done,
    output logic [2:0]       status,
    output logic [31:0]      sequence_mark,
    output logic [3:0]       events_found
);

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_SEQ   = 3'd1,
        PH_COUNT = 3'd2,
        PH_LEN   = 3'd3,
        PH_BODY  = 3'd4,
        PH_TAIL  = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         magic_pos_reg, magic_pos_next;
    logic [31:0]        hash_reg, hash_next;
    logic [31:0]        accum_reg, accum_next;
    logic               seen_reg, seen_next;
    logic [31:0]        seq_reg, seq_next;
    logic [3:0]         count_reg, count_next;
    logic [3:0]         index_reg, index_next;
    logic [31:0]        left_reg, left_next;
    jrv_pkg::status_t   err_reg, err_next;

    logic               out_valid_reg;
    logic               ev_valid_reg, ev_valid_next;
    logic [7:0]         ev_byte_reg, ev_byte_next;
    logic [2:0]         ev_index_reg, ev_index_next;
    logic               done_reg, done_next;
    jrv_pkg::status_t   status_reg, status_next;
    logic [31:0]        mark_reg, mark_next;
    logic [3:0]         found_reg, found_next;

    logic [35:0]        times_ten;
    logic               field_close;
    logic               magic_ok;
    logic [31:0]        mix;

    // A queued byte moves when the result register is free or being taken.
    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    assign mix       = hash_reg ^ {24'd0, q_entry.data};
    assign times_ten = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + {32'd0, q_entry.digit};

    always_comb
    begin
        case (magic_pos_reg)
            2'd0:    magic_ok = q_entry.magic_hit[0];
            2'd1:    magic_ok = q_entry.magic_hit[1];
            2'd2:    magic_ok = q_entry.magic_hit[2];
            default: magic_ok = 1'b0;
        endcase
    end

    // Hash, parse and status for the byte at the head of the queue.
    always_comb
    begin
        phase_next     = phase_reg;
        magic_pos_next = magic_pos_reg;
        hash_next      = mix * jrv_pkg::FNV_PRIME;
        accum_next     = accum_reg;
        seen_next      = seen_reg;
        seq_next       = seq_reg;
        count_next     = count_reg;
        index_next     = index_reg;
        left_next      = left_reg;
        err_next       = err_reg;
        field_close    = 1'b0;
        ev_valid_next  = 1'b0;
        ev_byte_next   = '0;
        ev_index_next  = '0;
        done_next      = 1'b0;
        status_next    = jrv_pkg::ST_OK;
        mark_next      = '0;
        found_next     = '0;

        if (err_reg == jrv_pkg::ST_OK)
        begin
            case (phase_reg)
                PH_MAGIC:
                begin
                    if (!magic_ok)
                    begin
                        err_next = jrv_pkg::ST_MAGIC;
                    end
                    else if (magic_pos_reg == 2'd2)
                    begin
                        phase_next     = PH_SEQ;
                        magic_pos_next = '0;
                    end
                    else
                    begin
                        magic_pos_next = magic_pos_reg + 1'b1;
                    end
                end
                PH_SEQ, PH_COUNT, PH_LEN:
                begin
                    if (q_entry.is_newline)
                    begin
                        if (!seen_reg)
                        begin
                            err_next = jrv_pkg::ST_NUMBER;
                        end
                        else
                        begin
                            field_close = 1'b1;
                        end
                    end
                    else if (!q_entry.is_digit || times_ten[35:32] != 4'd0)
                    begin
                        err_next = jrv_pkg::ST_NUMBER;
                    end
                    else
                    begin
                        accum_next = times_ten[31:0];
                        seen_next  = 1'b1;
                    end

                    // A newline closed a field: act on its value.
                    if (field_close)
                    begin
                        accum_next = '0;
                        seen_next  = 1'b0;
                        if (phase_reg == PH_SEQ)
                        begin
                            seq_next   = accum_reg;
                            phase_next = PH_COUNT;
                        end
                        else if (phase_reg == PH_COUNT)
                        begin
                            if (accum_reg > 32'(MAX_EVENTS))
                            begin
                                err_next = jrv_pkg::ST_COUNT;
                            end
                            else
                            begin
                                count_next = accum_reg[3:0];
                                index_next = '0;
                                phase_next = (accum_reg[3:0] == 4'd0) ? PH_TAIL : PH_LEN;
                            end
                        end
                        else if (accum_reg == '0)
                        begin
                            index_next = index_reg + 1'b1;
                            phase_next = (index_reg + 1'b1 >= count_reg) ? PH_TAIL : PH_LEN;
                        end
                        else
                        begin
                            left_next  = accum_reg;
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    ev_valid_next = 1'b1;
                    ev_byte_next  = q_entry.data;
                    ev_index_next = index_reg[2:0];
                    left_next     = left_reg - 1'b1;
                    if (left_reg == 32'd1)
                    begin
                        index_next = index_reg + 1'b1;
                        phase_next = (index_reg + 1'b1 >= count_reg) ? PH_TAIL : PH_LEN;
                    end
                end
                default:
                begin
                    err_next = jrv_pkg::ST_TRAIL;
                end
            endcase
        end

        // The final byte reports the status and rearms for the next record.
        if (q_entry.last)
        begin
            done_next  = 1'b1;
            mark_next  = seq_next;
            found_next = count_next;
            if (hash_next != q_entry.check)
            begin
                status_next = jrv_pkg::ST_CHECK;
            end
            else if (err_next != jrv_pkg::ST_OK)
            begin
                status_next = err_next;
            end
            else if (phase_next != PH_TAIL)
            begin
                status_next = jrv_pkg::ST_TRUNC;
            end
            phase_next     = PH_MAGIC;
            magic_pos_next = '0;
            hash_next      = jrv_pkg::FNV_BASIS;
            accum_next     = '0;
            seen_next      = 1'b0;
            seq_next       = '0;
            count_next     = '0;
            index_next     = '0;
            left_next      = '0;
            err_next       = jrv_pkg::ST_OK;
        end
    end

    // Parser state and the registered result, loaded with each popped byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            magic_pos_reg <= '0;
            hash_reg      <= jrv_pkg::FNV_BASIS;
            accum_reg     <= '0;
            seen_reg      <= 1'b0;
            seq_reg       <= '0;
            count_reg     <= '0;
            index_reg     <= '0;
            left_reg      <= '0;
            err_reg       <= jrv_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            ev_valid_reg  <= 1'b0;
            ev_byte_reg   <= '0;
            ev_index_reg  <= '0;
            done_reg      <= 1'b0;
            status_reg    <= jrv_pkg::ST_OK;
            mark_reg      <= '0;
            found_reg     <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                magic_pos_reg <= magic_pos_next;
                hash_reg      <= hash_next;
                accum_reg     <= accum_next;
                seen_reg      <= seen_next;
                seq_reg       <= seq_next;
                count_reg     <= count_next;
                index_reg     <= index_next;
                left_reg      <= left_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
                ev_valid_reg  <= ev_valid_next;
                ev_byte_reg   <= ev_byte_next;
                ev_index_reg  <= ev_index_next;
                done_reg      <= done_next;
                status_reg    <= status_next;
                mark_reg      <= mark_next;
                found_reg     <= found_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_byte_valid = ev_valid_reg;
    assign event_byte       = ev_byte_reg;
    assign event_index      = ev_index_reg;
    assign record_done      = done_reg;
    assign status           = status_reg;
    assign sequence_mark    = mark_reg;
    assign events_found     = found_reg;

endmodule

FILE: sv/journal_record_validator.sv
// ----------------------------------------------------------------------------
// Journal record validator
// Streams one stored journal record, checks its FNV-1a checksum and layout.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one record byte per
// transaction, with final_byte on the last one and stored_check sampled
// with it. The output channel (out_valid/out_ready) returns exactly one
// result transaction per input transaction, in order: event content bytes
// tagged with their event index, and on the final byte the record status,
// the parsed sequence value and the event count.
// An accepted byte passes the queue and then the result register before
// out_valid. Throughput is one byte per cycle while out_ready holds, set
// by the back end's combinational hash multiply and decimal accumulate.
// A four-entry queue between the classifier and the parser keeps the input
// open while a result waits; when the receiver stalls, input is accepted
// until the queue fills, then in_ready drops.
// Reset clears the queue and the parser, which then expects a new record.
// After each final byte the parser returns to its reset state by itself.
// ----------------------------------------------------------------------------
module journal_record_validator
#(
    parameter int MAX_EVENTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    input  logic [31:0] stored_check,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        event_byte_valid,
    output logic [7:0]  event_byte,
    output logic [2:0]  event_index,
    output logic        record_done,
    output logic [2:0]  status,
    output logic [31:0] sequence_mark,
    output logic [3:0]  events_found
);

    logic             q_valid;
    logic             q_pop;
    jrv_pkg::entry_t  q_entry;

    // Byte classification and decoupling queue.
    jrv_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .stored_check (stored_check),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    // Checksum, parser and result register.
    jrv_back #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_entry          (q_entry),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_byte_valid (event_byte_valid),
        .event_byte       (event_byte),
        .event_index      (event_index),
        .record_done      (record_done),
        .status           (status),
        .sequence_mark    (sequence_mark),
        .events_found     (events_found)
    );

endmodule

FILE: sv/jrv_checker.sv
// ----------------------------------------------------------------------------
// Journal record validator port checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
`include "journal_record_validator_defines.svh"

module jrv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        event_byte_valid,
    input logic [7:0]  event_byte,
    input logic [2:0]  event_index,
    input logic        record_done,
    input logic [2:0]  status,
    input logic [31:0] sequence_mark,
    input logic [3:0]  events_found
);

    // A stalled result stays offered with the same payload.
    `JRV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(event_byte) && $stable(sequence_mark))

    // Record summary fields read zero except on the final result.
    `JRV_ASSERT_IMPL(a_summary_zero, clk, rst_n, out_valid && !record_done, status == 3'd0 && sequence_mark == 32'd0 && events_found == 4'd0)

    // Content fields read zero except on event content.
    `JRV_ASSERT_IMPL(a_content_zero, clk, rst_n, out_valid && !event_byte_valid, event_byte == 8'd0 && event_index == 3'd0)

    // The status code never takes the unused encoding.
    `JRV_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, status != 3'd7)

endmodule

bind journal_record_validator jrv_checker u_jrv_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .event_byte_valid (event_byte_valid),
    .event_byte       (event_byte),
    .event_index      (event_index),
    .record_done      (record_done),
    .status           (status),
    .sequence_mark    (sequence_mark),
    .events_found     (events_found)
);
